// File: hdl/ccelw_pkg.sv
// ----------------------------------------------------------------------------
// ccelw_pkg
// Shared constants, register indexes and a helper function for the crank and
// cam edge-loss watchdog.
// ----------------------------------------------------------------------------
package ccelw_pkg;

   localparam int unsigned TIMER_W   = 10;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [TIMER_W-1:0] TIMER_LIMIT = 10'd600;

   localparam logic [CSR_IDX_W-1:0] REG_TICK_STEP             = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRANK_TIMEOUT         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRANK_TIMEOUT_INITIAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CAM_TIMEOUT           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CAM_TIMEOUT_INITIAL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTAKE_CAM_PRESENT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EXHAUST_CAM_PRESENT   = 3'd6;

   localparam logic [CSR_DATA_W-1:0] TICK_STEP_RESET       = 8'd10;
   localparam logic [CSR_DATA_W-1:0] TIMEOUT_RESET         = 8'd100;
   localparam logic [CSR_DATA_W-1:0] TIMEOUT_INITIAL_RESET = 8'd200;

   // Next value of one missing-edge timer.
   function automatic logic [TIMER_W-1:0] timer_next(
      input logic                  act,
      input logic                  prev,
      input logic [TIMER_W-1:0]    timer,
      input logic [CSR_DATA_W-1:0] step
   );
      logic [TIMER_W-1:0] thr;
      logic [TIMER_W-1:0] step_ext;
      logic [TIMER_W-1:0] result;
      step_ext = {{(TIMER_W-CSR_DATA_W){1'b0}}, step};
      thr      = (TIMER_LIMIT > step_ext) ? (TIMER_LIMIT - step_ext) : '0;
      if (act) begin
         if (!prev) begin
            result = '0;
         end else if (timer > TIMER_LIMIT) begin
            result = TIMER_LIMIT;
         end else begin
            result = timer;
         end
      end else if (timer < thr) begin
         result = timer + step_ext;
      end else begin
         result = TIMER_LIMIT;
      end
      return result;
   endfunction

endpackage

// File: hdl/crank_cam_edge_loss_watchdog.sv
// ----------------------------------------------------------------------------
// crank_cam_edge_loss_watchdog
// Missing-edge watchdog for the crank, intake cam and exhaust cam channels.
// ----------------------------------------------------------------------------
// Each accepted item is one scheduler tick and yields exactly one result item
// in the next cycle. Edge detection, the seen latches and the per-channel
// timers are updated in the cycle of acceptance, and the result is held in an
// output register, so a new tick is taken every clock while the result side
// keeps up; when the result side stalls, the input waits only until the held
// result is taken. The user writes configuration registers through the csr
// port only with no tick in flight, not enforced; unused indexes are ignored.
module crank_cam_edge_loss_watchdog (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [ccelw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccelw_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ccelw_pkg::COUNT_W-1:0]        req_crank_edge_count,
   input  logic [ccelw_pkg::COUNT_W-1:0]        req_intake_edge_count,
   input  logic [ccelw_pkg::COUNT_W-1:0]        req_exhaust_edge_count,
   input  logic                                 req_stuck_engine_start,
   input  logic                                 req_machine_start_event,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_crank_edge_now,
   output logic                                 rsp_intake_edge_now,
   output logic                                 rsp_exhaust_edge_now,
   output logic                                 rsp_crank_seen_since_start,
   output logic                                 rsp_intake_seen_since_start,
   output logic                                 rsp_exhaust_seen_since_start,
   output logic                                 rsp_crank_missing,
   output logic                                 rsp_intake_missing,
   output logic                                 rsp_exhaust_missing,
   output logic [ccelw_pkg::TIMER_W-1:0]        rsp_crank_timer_value,
   output logic [ccelw_pkg::TIMER_W-1:0]        rsp_intake_timer_value,
   output logic [ccelw_pkg::TIMER_W-1:0]        rsp_exhaust_timer_value
);

   logic [ccelw_pkg::CSR_DATA_W-1:0] tick_step_ff;
   logic [ccelw_pkg::CSR_DATA_W-1:0] crank_timeout_ff;
   logic [ccelw_pkg::CSR_DATA_W-1:0] crank_timeout_initial_ff;
   logic [ccelw_pkg::CSR_DATA_W-1:0] cam_timeout_ff;
   logic [ccelw_pkg::CSR_DATA_W-1:0] cam_timeout_initial_ff;
   logic                             intake_present_ff;
   logic                             exhaust_present_ff;

   logic [ccelw_pkg::COUNT_W-1:0] last_crank_ff, last_crank_in;
   logic [ccelw_pkg::COUNT_W-1:0] last_intake_ff, last_intake_in;
   logic [ccelw_pkg::COUNT_W-1:0] last_exhaust_ff, last_exhaust_in;
   logic crank_latch_ff, crank_latch_in;
   logic intake_latch_ff, intake_latch_in;
   logic exhaust_latch_ff, exhaust_latch_in;
   logic [ccelw_pkg::TIMER_W-1:0] crank_timer_ff, crank_timer_in;
   logic [ccelw_pkg::TIMER_W-1:0] intake_timer_ff, intake_timer_in;
   logic [ccelw_pkg::TIMER_W-1:0] exhaust_timer_ff, exhaust_timer_in;
   logic crank_act_ff, crank_act_in;
   logic intake_act_ff, intake_act_in;
   logic exhaust_act_ff, exhaust_act_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic crank_edge_ff, intake_edge_ff, exhaust_edge_ff;
   logic crank_seen_ff, intake_seen_ff, exhaust_seen_ff;
   logic crank_miss_ff, intake_miss_ff, exhaust_miss_ff;
   logic [ccelw_pkg::TIMER_W-1:0] crank_tval_ff, intake_tval_ff, exhaust_tval_ff;

   logic accept;
   logic ev;
   logic crank_edge, intake_edge_raw, exhaust_edge_raw;
   logic intake_edge, exhaust_edge;
   logic intake_seen, exhaust_seen;
   logic [ccelw_pkg::CSR_DATA_W-1:0] crank_thr, intake_thr, exhaust_thr;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff             <= ccelw_pkg::TICK_STEP_RESET;
         crank_timeout_ff         <= ccelw_pkg::TIMEOUT_RESET;
         crank_timeout_initial_ff <= ccelw_pkg::TIMEOUT_INITIAL_RESET;
         cam_timeout_ff           <= ccelw_pkg::TIMEOUT_RESET;
         cam_timeout_initial_ff   <= ccelw_pkg::TIMEOUT_INITIAL_RESET;
         intake_present_ff        <= 1'b1;
         exhaust_present_ff       <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ccelw_pkg::REG_TICK_STEP:             tick_step_ff <= csr_wdata;
            ccelw_pkg::REG_CRANK_TIMEOUT:         crank_timeout_ff <= csr_wdata;
            ccelw_pkg::REG_CRANK_TIMEOUT_INITIAL: crank_timeout_initial_ff <= csr_wdata;
            ccelw_pkg::REG_CAM_TIMEOUT:           cam_timeout_ff <= csr_wdata;
            ccelw_pkg::REG_CAM_TIMEOUT_INITIAL:   cam_timeout_initial_ff <= csr_wdata;
            ccelw_pkg::REG_INTAKE_CAM_PRESENT:    intake_present_ff <= csr_wdata[0];
            ccelw_pkg::REG_EXHAUST_CAM_PRESENT:   exhaust_present_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Edge detection, seen latches and timers for one tick.
   always_comb begin
      ev = req_stuck_engine_start || req_machine_start_event;

      crank_edge       = !req_stuck_engine_start && (req_crank_edge_count != last_crank_ff);
      intake_edge_raw  = !req_stuck_engine_start && (req_intake_edge_count != last_intake_ff);
      exhaust_edge_raw = !req_stuck_engine_start && (req_exhaust_edge_count != last_exhaust_ff);

      crank_latch_in   = !req_machine_start_event &&
                         (crank_edge || crank_latch_ff || req_stuck_engine_start);
      intake_latch_in  = !req_machine_start_event &&
                         (intake_edge_raw || intake_latch_ff || req_stuck_engine_start);
      exhaust_latch_in = !req_machine_start_event &&
                         (exhaust_edge_raw || exhaust_latch_ff || req_stuck_engine_start);

      last_crank_in   = req_crank_edge_count;
      last_intake_in  = req_intake_edge_count;
      last_exhaust_in = req_exhaust_edge_count;

      intake_edge  = intake_present_ff && intake_edge_raw;
      exhaust_edge = exhaust_present_ff && exhaust_edge_raw;
      intake_seen  = intake_present_ff && intake_latch_in;
      exhaust_seen = exhaust_present_ff && exhaust_latch_in;

      crank_act_in   = crank_edge || ev;
      intake_act_in  = intake_edge || ev;
      exhaust_act_in = exhaust_edge || ev;

      crank_timer_in   = ccelw_pkg::timer_next(crank_act_in, crank_act_ff,
                                               crank_timer_ff, tick_step_ff);
      intake_timer_in  = ccelw_pkg::timer_next(intake_act_in, intake_act_ff,
                                               intake_timer_ff, tick_step_ff);
      exhaust_timer_in = ccelw_pkg::timer_next(exhaust_act_in, exhaust_act_ff,
                                               exhaust_timer_ff, tick_step_ff);

      crank_thr   = crank_latch_in ? crank_timeout_ff : crank_timeout_initial_ff;
      intake_thr  = intake_seen ? cam_timeout_ff : cam_timeout_initial_ff;
      exhaust_thr = exhaust_seen ? cam_timeout_ff : cam_timeout_initial_ff;

      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   // Channel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_crank_ff    <= '0;
         last_intake_ff   <= '0;
         last_exhaust_ff  <= '0;
         crank_latch_ff   <= 1'b0;
         intake_latch_ff  <= 1'b0;
         exhaust_latch_ff <= 1'b0;
         crank_timer_ff   <= '0;
         intake_timer_ff  <= '0;
         exhaust_timer_ff <= '0;
         crank_act_ff     <= 1'b0;
         intake_act_ff    <= 1'b0;
         exhaust_act_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            last_crank_ff    <= last_crank_in;
            last_intake_ff   <= last_intake_in;
            last_exhaust_ff  <= last_exhaust_in;
            crank_latch_ff   <= crank_latch_in;
            intake_latch_ff  <= intake_latch_in;
            exhaust_latch_ff <= exhaust_latch_in;
            crank_timer_ff   <= crank_timer_in;
            intake_timer_ff  <= intake_timer_in;
            exhaust_timer_ff <= exhaust_timer_in;
            crank_act_ff     <= crank_act_in;
            intake_act_ff    <= intake_act_in;
            exhaust_act_ff   <= exhaust_act_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (accept) begin
         crank_edge_ff   <= crank_edge;
         intake_edge_ff  <= intake_edge;
         exhaust_edge_ff <= exhaust_edge;
         crank_seen_ff   <= crank_latch_in;
         intake_seen_ff  <= intake_seen;
         exhaust_seen_ff <= exhaust_seen;
         crank_miss_ff   <= crank_timer_in >=
                            {{(ccelw_pkg::TIMER_W-ccelw_pkg::CSR_DATA_W){1'b0}}, crank_thr};
         intake_miss_ff  <= intake_timer_in >=
                            {{(ccelw_pkg::TIMER_W-ccelw_pkg::CSR_DATA_W){1'b0}}, intake_thr};
         exhaust_miss_ff <= exhaust_timer_in >=
                            {{(ccelw_pkg::TIMER_W-ccelw_pkg::CSR_DATA_W){1'b0}}, exhaust_thr};
         crank_tval_ff   <= crank_timer_in;
         intake_tval_ff  <= intake_timer_in;
         exhaust_tval_ff <= exhaust_timer_in;
      end
   end

   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_crank_edge_now           = crank_edge_ff;
   assign rsp_intake_edge_now          = intake_edge_ff;
   assign rsp_exhaust_edge_now         = exhaust_edge_ff;
   assign rsp_crank_seen_since_start   = crank_seen_ff;
   assign rsp_intake_seen_since_start  = intake_seen_ff;
   assign rsp_exhaust_seen_since_start = exhaust_seen_ff;
   assign rsp_crank_missing            = crank_miss_ff;
   assign rsp_intake_missing           = intake_miss_ff;
   assign rsp_exhaust_missing          = exhaust_miss_ff;
   assign rsp_crank_timer_value        = crank_tval_ff;
   assign rsp_intake_timer_value       = intake_tval_ff;
   assign rsp_exhaust_timer_value      = exhaust_tval_ff;

   a_timers_bounded: assert property (@(posedge clock) disable iff (reset)
      crank_timer_ff <= ccelw_pkg::TIMER_LIMIT && intake_timer_ff <= ccelw_pkg::TIMER_LIMIT &&
      exhaust_timer_ff <= ccelw_pkg::TIMER_LIMIT)
      else $error("missing-edge timer above its limit");

   a_start_clears_seen: assert property (@(posedge clock) disable iff (reset)
      accept && req_machine_start_event |=>
         !rsp_crank_seen_since_start && !rsp_intake_seen_since_start &&
         !rsp_exhaust_seen_since_start)
      else $error("seen flag set after a machine start item");

   a_stuck_sets_seen: assert property (@(posedge clock) disable iff (reset)
      accept && req_stuck_engine_start && !req_machine_start_event |=>
         rsp_crank_seen_since_start && !rsp_crank_edge_now)
      else $error("stuck start item did not set the crank seen flag");

   a_absent_cam_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && !intake_present_ff |=> !rsp_intake_edge_now && !rsp_intake_seen_since_start)
      else $error("absent intake cam reported an edge");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !accept)
      else $error("item accepted over a held result");

endmodule

// File: dv/crank_cam_edge_loss_watchdog_tb.sv
// ----------------------------------------------------------------------------
// crank_cam_edge_loss_watchdog_tb
// Self-checking testbench for the crank and cam edge-loss watchdog. A short
// table of directed ticks is followed by several phases of random ticks, each
// under its own register settings. Every tick result is checked field by field
// against a behavioural model of the three channels, or against the expected
// result in its table row. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module crank_cam_edge_loss_watchdog_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ccelw_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int TIMER_SAT = int'(ccelw_pkg::TIMER_LIMIT);
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 145;

   typedef struct packed {
      logic [2:0]                         edge_now;
      logic [2:0]                         seen;
      logic [2:0]                         missing;
      logic [2:0][ccelw_pkg::TIMER_W-1:0] timer;
   } tick_result_type;

   typedef struct packed {
      logic [2:0][ccelw_pkg::COUNT_W-1:0] cnt;
      logic                               stuck;
      logic                               start;
      logic                               typed;
      tick_result_type                    want;
   } tick_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_write_en = 1'b0;
   logic [ccelw_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ccelw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [ccelw_pkg::COUNT_W-1:0]    req_crank_edge_count = '0;
   logic [ccelw_pkg::COUNT_W-1:0]    req_intake_edge_count = '0;
   logic [ccelw_pkg::COUNT_W-1:0]    req_exhaust_edge_count = '0;
   logic                             req_stuck_engine_start = 1'b0;
   logic                             req_machine_start_event = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_crank_edge_now;
   logic                             rsp_intake_edge_now;
   logic                             rsp_exhaust_edge_now;
   logic                             rsp_crank_seen_since_start;
   logic                             rsp_intake_seen_since_start;
   logic                             rsp_exhaust_seen_since_start;
   logic                             rsp_crank_missing;
   logic                             rsp_intake_missing;
   logic                             rsp_exhaust_missing;
   logic [ccelw_pkg::TIMER_W-1:0]    rsp_crank_timer_value;
   logic [ccelw_pkg::TIMER_W-1:0]    rsp_intake_timer_value;
   logic [ccelw_pkg::TIMER_W-1:0]    rsp_exhaust_timer_value;

   logic                  drv_typed = 1'b0;
   tick_result_type       drv_want = '0;
   logic                  send_idle_en = 1'b0;
   logic                  rsp_idle_en = 1'b0;
   int                    stall_left = 0;
   int                    mismatch_count = 0;

   int                    cfg_step;
   int                    cfg_crank_to;
   int                    cfg_crank_init;
   int                    cfg_cam_to;
   int                    cfg_cam_init;
   logic                  cfg_present [3];

   logic [ccelw_pkg::COUNT_W-1:0] last_count [3];
   logic                          seen_latch [3];
   logic [ccelw_pkg::TIMER_W-1:0] chan_timer [3];
   logic                          act_prev [3];

   tick_result_type       tick_results_due [$];
   tick_result_type       got_result;
   tick_result_type       want_result;
   tick_row_type          dir_rows [$];
   logic [2:0][ccelw_pkg::COUNT_W-1:0] cur_count = '0;
   int                    burst_left [3] = '{0, 0, 0};
   int                    edge_rate [3] = '{0, 0, 0};

   string                 ch_name [3] = '{"crank", "intake", "exhaust"};

   crank_cam_edge_loss_watchdog DUT (
      .clock                        (clock),
      .reset                        (reset),
      .csr_write_en                 (csr_write_en),
      .csr_index                    (csr_index),
      .csr_wdata                    (csr_wdata),
      .req_valid                    (req_valid),
      .req_ready                    (req_ready),
      .req_crank_edge_count         (req_crank_edge_count),
      .req_intake_edge_count        (req_intake_edge_count),
      .req_exhaust_edge_count       (req_exhaust_edge_count),
      .req_stuck_engine_start       (req_stuck_engine_start),
      .req_machine_start_event      (req_machine_start_event),
      .rsp_valid                    (rsp_valid),
      .rsp_ready                    (rsp_ready),
      .rsp_crank_edge_now           (rsp_crank_edge_now),
      .rsp_intake_edge_now          (rsp_intake_edge_now),
      .rsp_exhaust_edge_now         (rsp_exhaust_edge_now),
      .rsp_crank_seen_since_start   (rsp_crank_seen_since_start),
      .rsp_intake_seen_since_start  (rsp_intake_seen_since_start),
      .rsp_exhaust_seen_since_start (rsp_exhaust_seen_since_start),
      .rsp_crank_missing            (rsp_crank_missing),
      .rsp_intake_missing           (rsp_intake_missing),
      .rsp_exhaust_missing          (rsp_exhaust_missing),
      .rsp_crank_timer_value        (rsp_crank_timer_value),
      .rsp_intake_timer_value       (rsp_intake_timer_value),
      .rsp_exhaust_timer_value      (rsp_exhaust_timer_value)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [ccelw_pkg::TIMER_W-1:0] next_timer(
      input logic act, input logic prev, input logic [ccelw_pkg::TIMER_W-1:0] t);
      int thr;
      if (act) begin
         if (!prev) begin
            return '0;
         end else if (int'(t) > TIMER_SAT) begin
            return ccelw_pkg::TIMER_W'(TIMER_SAT);
         end
         return t;
      end
      thr = (TIMER_SAT > cfg_step) ? TIMER_SAT - cfg_step : 0;
      if (int'(t) < thr) begin
         return ccelw_pkg::TIMER_W'(int'(t) + cfg_step);
      end
      return ccelw_pkg::TIMER_W'(TIMER_SAT);
   endfunction

   function automatic tick_result_type predict_tick(
      input logic [2:0][ccelw_pkg::COUNT_W-1:0] cnt, input logic stuck, input logic start);
      tick_result_type r;
      logic            raw_edge;
      logic            act;
      int              limit_sel;
      r = '0;
      for (int c = 0; c < 3; c++) begin
         raw_edge = stuck ? 1'b0 : (cnt[c] != last_count[c]);
         seen_latch[c] = start ? 1'b0 : (raw_edge | stuck | seen_latch[c]);
         last_count[c] = cnt[c];
         r.edge_now[c] = raw_edge & cfg_present[c];
         r.seen[c] = seen_latch[c] & cfg_present[c];
         act = stuck | start | r.edge_now[c];
         chan_timer[c] = next_timer(act, act_prev[c], chan_timer[c]);
         act_prev[c] = act;
         if (c == 0) begin
            limit_sel = r.seen[c] ? cfg_crank_to : cfg_crank_init;
         end else begin
            limit_sel = r.seen[c] ? cfg_cam_to : cfg_cam_init;
         end
         r.missing[c] = (int'(chan_timer[c]) >= limit_sel);
         r.timer[c] = chan_timer[c];
      end
      return r;
   endfunction

   function automatic tick_result_type uniform_result(
      input logic [2:0] e, input logic [2:0] s, input logic [2:0] m,
      input logic [ccelw_pkg::TIMER_W-1:0] t);
      tick_result_type r;
      r.edge_now = e;
      r.seen = s;
      r.missing = m;
      r.timer = {t, t, t};
      return r;
   endfunction

   function automatic tick_row_type row(input logic [7:0] ck, input logic [7:0] ci,
                                        input logic [7:0] ce, input logic stuck,
                                        input logic start, input logic typed,
                                        input tick_result_type want);
      tick_row_type r;
      r.cnt = {ce, ci, ck};
      r.stuck = stuck;
      r.start = start;
      r.typed = typed;
      r.want = want;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic compare_result(input tick_result_type want, input tick_result_type got);
      for (int c = 0; c < 3; c++) begin
         check_field({ch_name[c], "_edge_now"}, int'(want.edge_now[c]),
                     int'(got.edge_now[c]));
         check_field({ch_name[c], "_seen_since_start"}, int'(want.seen[c]),
                     int'(got.seen[c]));
         check_field({ch_name[c], "_missing"}, int'(want.missing[c]),
                     int'(got.missing[c]));
         check_field({ch_name[c], "_timer_value"}, int'(want.timer[c]),
                     int'(got.timer[c]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            last_count[c] = '0;
            seen_latch[c] = 1'b0;
            chan_timer[c] = '0;
            act_prev[c] = 1'b0;
         end
         tick_results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_result.edge_now = {rsp_exhaust_edge_now, rsp_intake_edge_now,
                                   rsp_crank_edge_now};
            got_result.seen = {rsp_exhaust_seen_since_start, rsp_intake_seen_since_start,
                               rsp_crank_seen_since_start};
            got_result.missing = {rsp_exhaust_missing, rsp_intake_missing,
                                  rsp_crank_missing};
            got_result.timer = {rsp_exhaust_timer_value, rsp_intake_timer_value,
                                rsp_crank_timer_value};
            if (tick_results_due.size() == 0) begin
               $display("%0t: result item arrived with no item outstanding", $time);
               mismatch_count++;
            end else begin
               compare_result(tick_results_due.pop_front(), got_result);
            end
         end
         if (req_valid && req_ready) begin
            want_result = predict_tick({req_exhaust_edge_count, req_intake_edge_count,
                                        req_crank_edge_count},
                                       req_stuck_engine_start, req_machine_start_event);
            tick_results_due.push_back(drv_typed ? drv_want : want_result);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_idle_en && $urandom_range(99) < 15) begin
         rsp_ready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [2:0][ccelw_pkg::COUNT_W-1:0] cnt, input logic stuck,
                            input logic start, input logic typed,
                            input tick_result_type want);
      int gap;
      req_valid <= 1'b1;
      req_crank_edge_count <= cnt[0];
      req_intake_edge_count <= cnt[1];
      req_exhaust_edge_count <= cnt[2];
      req_stuck_engine_start <= stuck;
      req_machine_start_event <= start;
      drv_typed <= typed;
      drv_want <= want;
      do @(posedge clock); while (!req_ready);
      gap = (send_idle_en && $urandom_range(99) < 30) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The first edge lets the monitor record an item accepted at the previous edge.
   task automatic wait_drain();
      @(posedge clock);
      while (tick_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ccelw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ccelw_pkg::CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] step, input logic [7:0] crank_to,
                                 input logic [7:0] crank_init, input logic [7:0] cam_to,
                                 input logic [7:0] cam_init, input logic [7:0] intake_on,
                                 input logic [7:0] exhaust_on);
      req_valid <= 1'b0;
      wait_drain();
      repeat (2) @(posedge clock);
      write_reg(ccelw_pkg::REG_TICK_STEP, step);
      write_reg(ccelw_pkg::REG_CRANK_TIMEOUT, crank_to);
      write_reg(ccelw_pkg::REG_CRANK_TIMEOUT_INITIAL, crank_init);
      write_reg(ccelw_pkg::REG_CAM_TIMEOUT, cam_to);
      write_reg(ccelw_pkg::REG_CAM_TIMEOUT_INITIAL, cam_init);
      write_reg(ccelw_pkg::REG_INTAKE_CAM_PRESENT, intake_on);
      write_reg(ccelw_pkg::REG_EXHAUST_CAM_PRESENT, exhaust_on);
      write_reg(REG_UNUSED, 8'($urandom));
      csr_write_en <= 1'b0;
      cfg_step = int'(step);
      cfg_crank_to = int'(crank_to);
      cfg_crank_init = int'(crank_init);
      cfg_cam_to = int'(cam_to);
      cfg_cam_init = int'(cam_init);
      cfg_present[1] = intake_on[0];
      cfg_present[2] = exhaust_on[0];
   endtask

   task automatic run_rows(input int lo, input int hi);
      for (int i = lo; i < hi; i++) begin
         send_item(dir_rows[i].cnt, dir_rows[i].stuck, dir_rows[i].start,
                   dir_rows[i].typed, dir_rows[i].want);
      end
   endtask

   task automatic random_tick();
      logic stuck;
      logic start;
      int   r;
      for (int c = 0; c < 3; c++) begin
         if (burst_left[c] == 0) begin
            r = $urandom_range(99);
            edge_rate[c] = (r < 35) ? 0 : (r < 55) ? 5 : (r < 80) ? 30 : 95;
            burst_left[c] = $urandom_range(10, 80);
         end
         burst_left[c]--;
         if ($urandom_range(99) < 2) begin
            cur_count[c] = 8'($urandom);
         end else if ($urandom_range(99) < edge_rate[c]) begin
            cur_count[c] = cur_count[c] + 8'($urandom_range(1, 255));
         end
      end
      stuck = ($urandom_range(99) < 3);
      start = ($urandom_range(99) < 3);
      send_item(cur_count, stuck, start, 1'b0, '0);
   endtask

   initial begin
      logic [7:0] st;
      logic [7:0] t1;
      logic [7:0] t2;
      logic [7:0] t3;
      logic [7:0] t4;
      logic [7:0] ip;
      logic [7:0] ep;
      cfg_step = int'(ccelw_pkg::TICK_STEP_RESET);
      cfg_crank_to = int'(ccelw_pkg::TIMEOUT_RESET);
      cfg_crank_init = int'(ccelw_pkg::TIMEOUT_INITIAL_RESET);
      cfg_cam_to = int'(ccelw_pkg::TIMEOUT_RESET);
      cfg_cam_init = int'(ccelw_pkg::TIMEOUT_INITIAL_RESET);
      cfg_present[0] = 1'b1;
      cfg_present[1] = 1'b1;
      cfg_present[2] = 1'b1;

      // Rows up to the first 14 run under the reset settings.
      dir_rows.push_back(row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1,
                             uniform_result(3'd0, 3'd0, 3'd0, 10'd10)));
      dir_rows.push_back(row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1,
                             uniform_result(3'd7, 3'd7, 3'd0, 10'd0)));
      dir_rows.push_back(row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1,
                             uniform_result(3'd0, 3'd7, 3'd0, 10'd10)));
      dir_rows.push_back(row(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5A, 8'hA5, 8'h3C, 1'b0, 1'b1, 1'b0, '0));
      dir_rows.push_back(row(8'h5A, 8'hA5, 8'h3C, 1'b1, 1'b1, 1'b0, '0));
      dir_rows.push_back(row(8'h5A, 8'hA5, 8'h3C, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5B, 8'hA5, 8'h3C, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5B, 8'hA4, 8'h3C, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5B, 8'hA4, 8'h3D, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5C, 8'hA3, 8'h3E, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h5D, 8'hA2, 8'h3F, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h80, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h80, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h80, 8'h80, 8'h01, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h81, 8'h80, 8'h02, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h81, 8'h80, 8'h02, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h81, 8'h80, 8'h02, 1'b0, 1'b1, 1'b0, '0));
      dir_rows.push_back(row(8'h81, 8'h00, 8'h02, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h81, 8'h00, 8'h02, 1'b1, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0));
      dir_rows.push_back(row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      run_rows(0, 14);
      // Zero step, intake cam absent through a wide write, extreme timeouts.
      apply_settings(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'hFE, 8'h01);
      run_rows(14, dir_rows.size());

      for (int p = 0; p < PHASES; p++) begin
         st = (($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 30)));
         t1 = 8'($urandom);
         t2 = 8'($urandom);
         t3 = 8'($urandom);
         t4 = 8'($urandom);
         ip = 8'($urandom);
         ep = 8'($urandom);
         case (p)
            0: apply_settings(ccelw_pkg::TICK_STEP_RESET, ccelw_pkg::TIMEOUT_RESET,
                              ccelw_pkg::TIMEOUT_INITIAL_RESET, ccelw_pkg::TIMEOUT_RESET,
                              ccelw_pkg::TIMEOUT_INITIAL_RESET, 8'h01, 8'h01);
            1: apply_settings(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'h01, 8'hFF);
            2: apply_settings(8'd1, 8'd255, 8'd0, 8'd255, 8'd0, 8'h00, 8'h01);
            3: apply_settings(8'd0, t1, t2, t3, t4, 8'h01, 8'h00);
            default: apply_settings(st, t1, t2, t3, t4, ip, ep);
         endcase
         send_idle_en = (p != 0) && ($urandom_range(3) != 0);
         rsp_idle_en = (p != 0) && ($urandom_range(3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               wait_drain();
            end
            random_tick();
         end
      end

      req_valid <= 1'b0;
      send_idle_en = 1'b0;
      wait_drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("crank_cam_edge_loss_watchdog_tb passed");
      end else begin
         $display("crank_cam_edge_loss_watchdog_tb failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("crank_cam_edge_loss_watchdog_tb failed");
      $finish;
   end

endmodule

// File: crank_cam_edge_loss_watchdog.f
hdl/ccelw_pkg.sv
hdl/crank_cam_edge_loss_watchdog.sv
dv/crank_cam_edge_loss_watchdog_tb.sv
